@@ rtl/mbfr_pkg.sv @@
package mbfr_pkg;

    // store and field sizes fixed by the datapath widths
    localparam int BUFFER_BYTES   = 4096;
    localparam int MAX_FIELD_BITS = 32;

    typedef enum logic [2:0] {
        CMD_LOAD     = 3'd0,
        CMD_READ     = 3'd1,
        CMD_SKIP     = 3'd2,
        CMD_SET_POS  = 3'd3,
        CMD_READ_STR = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ERR_OK        = 3'd0,
        ERR_ZERO      = 3'd1,
        ERR_TOO_WIDE  = 3'd2,
        ERR_NOT_BYTE  = 3'd3,
        ERR_PAST_END  = 3'd4
    } err_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [11:0] byte_address;
        logic [7:0]  byte_value;
        logic [9:0]  bit_count;
        logic [15:0] new_position;
    } in_item_t;

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  error_code;
        logic        last;
        logic        missing_string;
        logic [15:0] position;
        logic [15:0] remaining_bits;
    } out_item_t;

    // classified job handed from front to back
    typedef enum logic [1:0] {
        JOB_NONE  = 2'd0,
        JOB_FIELD = 2'd1,
        JOB_STR   = 2'd2
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [2:0]  err;
        logic [16:0] start;
        logic [9:0]  count;
        logic [15:0] pos_after;
        logic [15:0] remaining;
    } job_t;

    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_FETCH = 2'd1,
        BK_EMIT  = 2'd2
    } bk_state_t;

endpackage

@@ rtl/mbfr_front.sv @@
module mbfr_front
    import mbfr_pkg::*;
#(
    parameter int MAX_STRING_BYTES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        drained,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_item,
    output logic        wr_en,
    output logic [11:0] wr_addr,
    output logic [7:0]  wr_data,
    output logic        job_valid,
    input  logic        job_ready,
    output job_t        job
);

    localparam logic [17:0] CAP = 18'(BUFFER_BYTES * 8);

    logic [15:0] len_reg;
    logic [15:0] cursor_reg, cursor_next;
    logic [17:0] endb, sum;
    logic [16:0] cur_nx17;
    logic        accept;
    job_t        job_c;

    // a load waits for all queued jobs so it cannot overtake an earlier read
    assign in_ready = (in_item.command == CMD_LOAD) ? (job_ready && drained) : job_ready;
    assign accept   = in_valid && in_ready;
    assign endb     = ({2'b0, len_reg} < CAP) ? {2'b0, len_reg} : CAP;
    assign sum      = {2'b0, cursor_reg} + 18'(in_item.bit_count);

    // store write for load transactions
    assign wr_en   = accept && (in_item.command == CMD_LOAD)
                     && (32'(in_item.byte_address) < 32'(BUFFER_BYTES));
    assign wr_addr = in_item.byte_address;
    assign wr_data = in_item.byte_value;

    // classify and check
    always_comb begin
        cursor_next   = cursor_reg;
        job_c         = '0;
        job_c.kind    = JOB_NONE;
        job_c.start   = {1'b0, cursor_reg};
        job_c.count   = in_item.bit_count;
        job_valid     = 1'b0;
        case (in_item.command)
            CMD_READ: begin
                job_valid = in_valid;
                if (in_item.bit_count == '0) job_c.err = ERR_ZERO;
                else if (32'(in_item.bit_count) > 32'(MAX_FIELD_BITS)) job_c.err = ERR_TOO_WIDE;
                else if (sum > endb) job_c.err = ERR_PAST_END;
                else begin
                    job_c.kind  = JOB_FIELD;
                    cursor_next = sum[15:0];
                end
            end
            CMD_SKIP: begin
                job_valid = in_valid;
                if (sum > endb) job_c.err = ERR_PAST_END;
                else cursor_next = sum[15:0];
            end
            CMD_SET_POS: begin
                job_valid   = in_valid;
                cursor_next = in_item.new_position;
            end
            CMD_READ_STR: begin
                job_valid = in_valid;
                if (in_item.bit_count == '0) job_c.err = ERR_ZERO;
                else if (in_item.bit_count[2:0] != 3'd0) job_c.err = ERR_NOT_BYTE;
                else if (32'(in_item.bit_count[9:3]) > 32'(MAX_STRING_BYTES))
                    job_c.err = ERR_TOO_WIDE;
                else if (sum > endb) job_c.err = ERR_PAST_END;
                else begin
                    job_c.kind  = JOB_STR;
                    cursor_next = sum[15:0];
                end
            end
            default: ;
        endcase
        job_c.pos_after = cursor_next;
        cur_nx17        = {1'b0, cursor_next};
        job_c.remaining = ({1'b0, cur_nx17} < endb) ? 16'(endb - {1'b0, cur_nx17}) : 16'd0;
    end

    assign job = job_c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg    <= '0;
            cursor_reg <= '0;
        end else begin
            if (cfg_we) len_reg <= cfg_wdata;
            if (accept) cursor_reg <= cursor_next;
        end
    end

endmodule

@@ rtl/mbfr_queue.sv @@
module mbfr_queue
    import mbfr_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic wr_valid,
    output logic wr_ready,
    input  job_t wr_job,
    output logic rd_valid,
    input  logic rd_ready,
    output job_t rd_job
);

    // two-entry job queue
    job_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_job   = mem_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= wr_job;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

@@ rtl/mbfr_back.sv @@
module mbfr_back
    import mbfr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        wr_en,
    input  logic [11:0] wr_addr,
    input  logic [7:0]  wr_data,
    input  logic        job_valid,
    output logic        job_ready,
    input  job_t        job,
    output logic        idle,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_item
);

    localparam int AW = $clog2(BUFFER_BYTES);

    logic [7:0]  mem [BUFFER_BYTES];
    logic [7:0]  rdata_reg;
    logic [AW-1:0] rd_addr;
    logic        rd_en;

    bk_state_t   state_reg, state_next;
    job_t        job_reg;
    logic [16:0] baddr_reg, baddr_next;     // next byte index to read
    logic [2:0]  nfetch_reg, nfetch_next;   // field bytes still to fetch
    logic        pend_reg, pend_next;       // fetched byte waiting in the read register
    logic [39:0] win_reg, win_next;         // field byte window
    logic [7:0]  pair_reg, pair_next;       // previous string byte
    logic [6:0]  left_reg, left_next;       // string bytes left to emit
    logic        allff_reg, allff_next;
    logic        first_reg, first_next;
    out_item_t   out_reg, out_next;
    logic        ov_reg, ov_next;
    logic        out_free;
    logic [5:0]  sh;
    logic [39:0] shifted;
    logic [7:0]  sbyte;
    logic [2:0]  off;
    logic [5:0]  fld_bits;

    // byte store
    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr[AW-1:0]] <= wr_data;
        if (rd_en) rdata_reg <= mem[rd_addr];
    end

    assign idle     = (state_reg == BK_IDLE);
    assign rd_addr  = baddr_reg[AW-1:0];
    assign out_free = !ov_reg || m_ready;
    assign off      = job_reg.start[2:0];
    assign fld_bits = 6'(job_reg.count) + 6'(off);
    assign sh       = 6'd40 - 6'(job_reg.count);
    assign shifted  = (win_reg << off) >> sh;
    assign sbyte    = 8'({pair_reg, rdata_reg} << off >> 8);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:  if (job_valid && out_free && job.kind != JOB_NONE) state_next = BK_FETCH;
            BK_FETCH: if (job_reg.kind == JOB_FIELD && nfetch_reg == 3'd0 && !pend_reg)
                          state_next = BK_EMIT;
                      else if (job_reg.kind == JOB_STR && left_reg == 7'd0)
                          state_next = BK_IDLE;
            BK_EMIT:  if (out_free) state_next = BK_IDLE;
            default:  state_next = BK_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        job_ready   = 1'b0;
        rd_en       = 1'b0;
        baddr_next  = baddr_reg;
        nfetch_next = nfetch_reg;
        pend_next   = 1'b0;
        win_next    = win_reg;
        pair_next   = pair_reg;
        left_next   = left_reg;
        allff_next  = allff_reg;
        first_next  = first_reg;
        out_next    = out_reg;
        ov_next     = ov_reg && !m_ready;
        case (state_reg)
            BK_IDLE: begin
                job_ready = out_free;
                if (job_valid && out_free) begin
                    baddr_next  = {3'b0, job.start[16:3]};
                    nfetch_next = 3'(({1'b0, job.count[5:0]} + 7'(job.start[2:0]) + 7'd7) >> 3);
                    left_next   = job.count[9:3];
                    allff_next  = 1'b1;
                    first_next  = 1'b1;
                    win_next    = '0;
                    if (job.kind == JOB_NONE) begin
                        out_next.value          = '0;
                        out_next.error_code     = job.err;
                        out_next.last           = 1'b1;
                        out_next.missing_string = 1'b0;
                        out_next.position       = job.pos_after;
                        out_next.remaining_bits = job.remaining;
                        ov_next                 = 1'b1;
                    end
                end
            end
            BK_FETCH: begin
                if (job_reg.kind == JOB_FIELD) begin
                    if (pend_reg) win_next = (win_reg << 8) | 40'(rdata_reg) << 0;
                    if (nfetch_reg != 3'd0) begin
                        rd_en       = 1'b1;
                        pend_next   = 1'b1;
                        baddr_next  = baddr_reg + 17'd1;
                        nfetch_next = nfetch_reg - 3'd1;
                    end else if (!pend_reg) begin
                        // left-align window: bytes fetched fill from the low end
                        win_next = win_reg << (6'd40 - 6'(((fld_bits + 6'd7) >> 3) << 3));
                    end
                end else begin
                    // string: keep one byte ahead, emit one byte per cycle while the output is free
                    if (pend_reg) pair_next = rdata_reg;
                    if (first_reg || (pend_reg && out_free)) begin
                        rd_en      = 1'b1;
                        pend_next  = 1'b1;
                        baddr_next = baddr_reg + 17'd1;
                    end else if (pend_reg) begin
                        // output stalled: the read register keeps the fetched byte
                        pend_next = 1'b1;
                        pair_next = pair_reg;
                    end
                    if (pend_reg && !first_reg && out_free && left_reg != 7'd0) begin
                        out_next.value          = {24'b0, sbyte};
                        out_next.error_code     = ERR_OK;
                        out_next.last           = (left_reg == 7'd1);
                        out_next.missing_string = (left_reg == 7'd1) && allff_reg
                                                  && (sbyte == 8'hff);
                        out_next.position       = job_reg.pos_after;
                        out_next.remaining_bits = job_reg.remaining;
                        ov_next                 = 1'b1;
                        allff_next              = allff_reg && (sbyte == 8'hff);
                        left_next               = left_reg - 7'd1;
                    end
                    if (pend_reg && first_reg) first_next = 1'b0;
                    if (left_reg == 7'd0) begin
                        rd_en     = 1'b0;
                        pend_next = 1'b0;
                    end
                end
            end
            BK_EMIT: begin
                if (out_free) begin
                    out_next.value          = shifted[31:0];
                    out_next.error_code     = ERR_OK;
                    out_next.last           = 1'b1;
                    out_next.missing_string = 1'b0;
                    out_next.position       = job_reg.pos_after;
                    out_next.remaining_bits = job_reg.remaining;
                    ov_next                 = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign m_valid = ov_reg;
    assign m_item  = out_reg;

    always_ff @(posedge aclk) begin
        if (job_ready && job_valid) job_reg <= job;
        baddr_reg  <= baddr_next;
        nfetch_reg <= nfetch_next;
        win_reg    <= win_next;
        pair_reg   <= pair_next;
        left_reg   <= left_next;
        allff_reg  <= allff_next;
        first_reg  <= first_next;
        out_reg    <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            ov_reg    <= 1'b0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            pend_reg  <= pend_next;
        end
    end

    // output register holds while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        ov_reg && !m_ready |=> ov_reg && $stable(out_reg))
        else $error("output changed while stalled");
    // no job taken while busy
    a_idle_take: assert property (@(posedge aclk) disable iff (!aresetn)
        job_ready |-> state_reg == BK_IDLE)
        else $error("job taken while busy");
    // emit state only serves field jobs
    a_str: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BK_EMIT |-> job_reg.kind == JOB_FIELD)
        else $error("emit state without field job");

endmodule

@@ rtl/msb_first_bit_field_reader_unit.sv @@
// MSB-first bit field reader. Loads fill a byte store with no result; reads take 1..32 bits
// at the bit cursor, skips and seeks move it, string reads return one byte per result.
// A front stage checks each transaction and updates the cursor register on accept; a two-entry
// queue feeds the back stage, which reads the byte store one byte per cycle while results are
// not stalled. A load waits until the queue and the back stage are empty. A field read fetches
// its spanned bytes (up to 5) and then emits one result, a string emits one result per byte,
// and errors, skips and seeks pass with no byte reads; a stalled result channel holds the back
// stage.
module msb_first_bit_field_reader_unit
    import mbfr_pkg::*;
#(
    parameter int MAX_STRING_BYTES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data
);

    logic        wr_en;
    logic [11:0] wr_addr;
    logic [7:0]  wr_data;
    logic        fq_valid, fq_ready, qb_valid, qb_ready;
    logic        bk_idle, drained;
    job_t        fq_job, qb_job;

    // nothing queued and no job in the back stage
    assign drained = !qb_valid && bk_idle;

    mbfr_front #(
        .MAX_STRING_BYTES(MAX_STRING_BYTES)
    ) u_front (
        .aclk, .aresetn, .cfg_we, .cfg_wdata, .drained,
        .in_valid(s_valid), .in_ready(s_ready), .in_item(s_data),
        .wr_en, .wr_addr, .wr_data,
        .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
    );

    mbfr_queue u_queue (
        .aclk, .aresetn,
        .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_job(fq_job),
        .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_job(qb_job)
    );

    mbfr_back u_back (
        .aclk, .aresetn, .wr_en, .wr_addr, .wr_data,
        .job_valid(qb_valid), .job_ready(qb_ready), .job(qb_job),
        .idle(bk_idle),
        .m_valid, .m_ready, .m_item(m_data)
    );

endmodule

@@ dv/msb_first_bit_field_reader_unit_test.sv @@
`timescale 1ns / 100ps

module msb_first_bit_field_reader_unit_test;
    import mbfr_pkg::*;

    localparam int STORE_BYTES = 4096;
    localparam int MAX_STR_BYTES = 64;
    localparam int MAX_FIELD = 32;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;

    msb_first_bit_field_reader_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // clock, 20 ns period
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // shadow state of the reader
    logic [7:0]  shadow_store [STORE_BYTES];
    bit          store_loaded [STORE_BYTES];
    logic [15:0] shadow_cursor;
    logic [15:0] shadow_length;

    in_item_t    pending_items [$];
    out_item_t   expected_results [$];
    int          mismatch_count;
    int          result_count;
    int          accepted_count;
    int          string_count;

    function automatic logic [15:0] end_bound();
        return (shadow_length < STORE_BYTES * 8) ? shadow_length : 16'(STORE_BYTES * 8);
    endfunction

    function automatic out_item_t make_result(logic [31:0] value, err_t err, logic last,
                                              logic missing);
        out_item_t r;
        logic [15:0] e;
        e = end_bound();
        r.value = value;
        r.error_code = err;
        r.last = last;
        r.missing_string = missing;
        r.position = shadow_cursor;
        r.remaining_bits = (shadow_cursor < e) ? e - shadow_cursor : 16'd0;
        return r;
    endfunction

    function automatic logic [7:0] byte_at_bit(int unsigned pos);
        logic [7:0] b;
        b = '0;
        for (int j = 0; j < 8; j++)
            b = {b[6:0], shadow_store[(pos + j) >> 3][7 - ((pos + j) & 7)]};
        return b;
    endfunction

    // true when a good read at the current cursor would touch a byte never loaded
    function automatic bit reads_unloaded(in_item_t it);
        int unsigned cur;
        int unsigned cnt;
        bit          good;
        cur = shadow_cursor;
        cnt = it.bit_count;
        good = 1'b0;
        if (it.command == CMD_READ)
            good = (cnt != 0) && (cnt <= MAX_FIELD) && (cur + cnt <= end_bound());
        else if (it.command == CMD_READ_STR)
            good = (cnt != 0) && (cnt[2:0] == 0) && ((cnt >> 3) <= MAX_STR_BYTES)
                   && (cur + cnt <= end_bound());
        if (!good) return 1'b0;
        for (int unsigned p = cur >> 3; p <= (cur + cnt - 1) >> 3; p++)
            if (!store_loaded[p]) return 1'b1;
        return 1'b0;
    endfunction

    // work out the results of one accepted transaction
    task automatic predict_reader(in_item_t it);
        int unsigned endb;
        int unsigned cur;
        int unsigned cnt;
        int unsigned nbytes;
        logic [31:0] acc;
        logic [7:0]  bytes [MAX_STR_BYTES];
        bit          all_ff;
        endb = end_bound();
        cur = shadow_cursor;
        cnt = it.bit_count;
        case (it.command)
            CMD_LOAD: begin
                shadow_store[it.byte_address] = it.byte_value;
                store_loaded[it.byte_address] = 1'b1;
            end
            CMD_READ: begin
                if (cnt == 0) expected_results.push_back(make_result(0, ERR_ZERO, 1, 0));
                else if (cnt > MAX_FIELD)
                    expected_results.push_back(make_result(0, ERR_TOO_WIDE, 1, 0));
                else if (cur + cnt > endb)
                    expected_results.push_back(make_result(0, ERR_PAST_END, 1, 0));
                else begin
                    acc = '0;
                    for (int i = 0; i < cnt; i++)
                        acc = {acc[30:0], shadow_store[(cur + i) >> 3][7 - ((cur + i) & 7)]};
                    shadow_cursor = 16'(cur + cnt);
                    expected_results.push_back(make_result(acc, ERR_OK, 1, 0));
                end
            end
            CMD_SKIP: begin
                if (cur + cnt > endb)
                    expected_results.push_back(make_result(0, ERR_PAST_END, 1, 0));
                else begin
                    shadow_cursor = 16'(cur + cnt);
                    expected_results.push_back(make_result(0, ERR_OK, 1, 0));
                end
            end
            CMD_SET_POS: begin
                shadow_cursor = it.new_position;
                expected_results.push_back(make_result(0, ERR_OK, 1, 0));
            end
            CMD_READ_STR: begin
                nbytes = cnt >> 3;
                if (cnt == 0) expected_results.push_back(make_result(0, ERR_ZERO, 1, 0));
                else if (cnt[2:0] != 0)
                    expected_results.push_back(make_result(0, ERR_NOT_BYTE, 1, 0));
                else if (nbytes > MAX_STR_BYTES)
                    expected_results.push_back(make_result(0, ERR_TOO_WIDE, 1, 0));
                else if (cur + cnt > endb)
                    expected_results.push_back(make_result(0, ERR_PAST_END, 1, 0));
                else begin
                    all_ff = 1'b1;
                    for (int i = 0; i < nbytes; i++) begin
                        bytes[i] = byte_at_bit(cur + i * 8);
                        if (bytes[i] != 8'hff) all_ff = 1'b0;
                    end
                    shadow_cursor = 16'(cur + cnt);
                    for (int i = 0; i < nbytes; i++)
                        expected_results.push_back(make_result({24'd0, bytes[i]}, ERR_OK,
                            i == nbytes - 1, (i == nbytes - 1) ? all_ff : 1'b0));
                    string_count++;
                end
            end
            default: ;
        endcase
    endtask

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // input driver
    int       drive_gap;
    bit       burst_mode;
    in_item_t next_item;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            drive_gap = 0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                predict_reader(s_data);
                accepted_count++;
            end
            if (drive_gap > 0) begin
                drive_gap--;
                s_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                next_item = pending_items.pop_front();
                // reads stay on loaded bytes: otherwise jump back to the start
                if (reads_unloaded(next_item)) begin
                    next_item.command = CMD_SET_POS;
                    next_item.new_position = '0;
                end
                s_data <= next_item;
                s_valid <= 1'b1;
                drive_gap = burst_mode ? 0 : gap_length();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result monitor and ready stalls
    int stall_left;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                result_count++;
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result transaction: %p", m_data);
                end else begin
                    out_item_t e;
                    e = expected_results.pop_front();
                    if (e !== m_data) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected %p, actual %p", e, m_data);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!burst_mode) stall_left = gap_length();
            end
        end
    end

    // wait until the block has drained everything sent so far
    task automatic wait_drained();
        while (pending_items.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_length(logic [15:0] len);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= len;
        @(posedge aclk);
        cfg_we <= 1'b0;
        shadow_length = len;
    endtask

    function automatic in_item_t make_cmd(cmd_t c, int cnt, int pos);
        in_item_t it;
        it = '0;
        it.command = c;
        it.bit_count = 10'(cnt);
        it.new_position = 16'(pos);
        it.byte_address = 12'($urandom);
        it.byte_value = 8'($urandom);
        return it;
    endfunction

    function automatic in_item_t make_load(int addr, int val);
        in_item_t it;
        it = '0;
        it.command = CMD_LOAD;
        it.byte_address = 12'(addr);
        it.byte_value = 8'(val);
        it.bit_count = 10'($urandom);
        it.new_position = 16'($urandom);
        return it;
    endfunction

    // random command at the cursor; the input driver keeps reads on loaded bytes
    function automatic in_item_t random_cmd(int unsigned loaded_bits);
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return make_cmd(CMD_READ, $urandom_range(1, MAX_FIELD), 0);
        if (r < 50) return make_cmd(CMD_SKIP, $urandom_range(0, 40), 0);
        if (r < 62) return make_cmd(CMD_SET_POS, 0, $urandom_range(0, loaded_bits));
        if (r < 80) return make_cmd(CMD_READ_STR, 8 * $urandom_range(1, 6), 0);
        if (r < 84) return make_cmd(CMD_READ_STR, 8 * $urandom_range(1, MAX_STR_BYTES), 0);
        if (r < 88) return make_cmd(CMD_READ, $urandom_range(0, 1023), 0);
        if (r < 92) return make_cmd(CMD_READ_STR, $urandom_range(0, 1023), 0);
        if (r < 96) return make_cmd(CMD_SET_POS, 0, $urandom);
        return make_cmd(cmd_t'($urandom_range(5, 7)), $urandom, $urandom);
    endfunction

    initial begin
        int unsigned loaded_bits;
        int unsigned phase_bytes;
        logic [15:0] len;
        mismatch_count = 0;
        result_count = 0;
        accepted_count = 0;
        string_count = 0;
        burst_mode = 0;
        shadow_cursor = '0;
        shadow_length = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reads with the buffer length still zero, then fill 96 bytes
        pending_items.push_back(make_cmd(CMD_READ, 1, 0));
        pending_items.push_back(make_cmd(CMD_SKIP, 0, 0));
        for (int a = 0; a < 96; a++)
            pending_items.push_back(make_load(a, (a < 8) ? 8'hff : (a == 8 ? 8'h00 : $urandom)));
        pending_items.push_back(make_load(4095, 8'hff));
        wait_drained();
        write_length(16'(96 * 8));
        pending_items.push_back(make_cmd(CMD_READ_STR, 64, 0));      // all 0xff string
        pending_items.push_back(make_cmd(CMD_SET_POS, 0, 3));
        pending_items.push_back(make_cmd(CMD_READ, 32, 0));          // widest, unaligned
        pending_items.push_back(make_cmd(CMD_READ, 0, 0));
        pending_items.push_back(make_cmd(CMD_READ, 33, 0));
        pending_items.push_back(make_cmd(CMD_READ, 1023, 0));
        pending_items.push_back(make_cmd(CMD_READ_STR, 0, 0));
        pending_items.push_back(make_cmd(CMD_READ_STR, 12, 0));
        pending_items.push_back(make_cmd(CMD_READ_STR, 520, 0));
        pending_items.push_back(make_cmd(CMD_READ_STR, 24, 0));      // unaligned string
        pending_items.push_back(make_cmd(CMD_SET_POS, 0, 96 * 8));   // exactly at end
        pending_items.push_back(make_cmd(CMD_READ, 1, 0));
        pending_items.push_back(make_cmd(CMD_SET_POS, 0, 16'hffff));  // beyond end
        pending_items.push_back(make_cmd(CMD_SKIP, 1, 0));
        pending_items.push_back(make_cmd(CMD_SET_POS, 0, 0));
        pending_items.push_back(make_cmd(CMD_READ_STR, 512, 0));     // longest string
        pending_items.push_back(make_cmd(CMD_SKIP, 0, 0));
        pending_items.push_back(make_cmd(CMD_SKIP, 1023, 0));
        pending_items.push_back(make_cmd(CMD_READ, 32, 0));
        pending_items.push_back(make_cmd(cmd_t'(3'd7), 5, 5));
        pending_items.push_back(make_cmd(CMD_SET_POS, 0, 0));
        wait_drained();

        // random phases, each writing a buffer length first
        for (int ph = 0; ph < 6; ph++) begin
            burst_mode = (ph == 3);
            phase_bytes = (ph == 5) ? 4096 : 96;
            loaded_bits = phase_bytes * 8;
            case (ph)
                0: len = 16'd0;
                1: len = 16'd32768;
                2: len = 16'd65535;
                5: len = 16'd32768;
                default: len = 16'($urandom_range(8, loaded_bits));
            endcase
            write_length(len);
            // fresh content in part of the store, 0xff now and then
            if (ph != 5)
                for (int a = 0; a < 16; a++)
                    pending_items.push_back(make_load($urandom_range(0, 95),
                        ($urandom_range(0, 3) == 0) ? 8'hff : $urandom));
            else
                for (int a = 4090; a < 4096; a++)
                    pending_items.push_back(make_load(a, $urandom));
            pending_items.push_back(make_cmd(CMD_SET_POS, 0,
                (ph == 5) ? 32768 - 48 : 0));
            for (int k = 0; k < 20; k++) begin
                in_item_t it;
                it = random_cmd((ph == 5) ? 0 : loaded_bits - 1);
                // last phase only touches the top of the store; reads stay in range
                if (ph == 5 && it.command == CMD_SET_POS)
                    it.new_position = 16'(32768 - 48 + $urandom_range(0, 48));
                pending_items.push_back(it);
            end
            wait_drained();
            // each phase first seeks to a cursor inside loaded bytes
        end

        $display("covered %0d transactions, %0d results, %0d good strings",
                 accepted_count, result_count, string_count);
        $display("buffer lengths 0, 32768, 65535 and random ones; directed error cases");
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("mismatches: %0d, left over: %0d", mismatch_count,
                     expected_results.size());
            $display("Test completed with failures");
        end
        $finish;
    end

    // watchdog
    initial begin
        #100ms;
        $display("timeout");
        $display("Test completed with failures");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/mbfr_pkg.sv
rtl/mbfr_front.sv
rtl/mbfr_queue.sv
rtl/mbfr_back.sv
rtl/msb_first_bit_field_reader_unit.sv
dv/msb_first_bit_field_reader_unit_test.sv
